>>> sv/fvpid_pkg.sv
// ----------------------------------------------------------------------------
// fvpid_pkg
// Types and constants shared by the flow velocity PID controller modules.
// ----------------------------------------------------------------------------
package fvpid_pkg;

   // speeds in 1/64 cm/s, gains unsigned Q4.12, terms in units of 2^-18
   localparam int TARGET_LIMIT = 1920;        // 30 cm/s
   localparam int DEAD_BAND    = 64;          // 1 cm/s
   localparam int QUALITY_MIN  = 20;
   localparam int INT_LIMIT    = 5242880;     // 40.0 in units of 2^-17
   localparam int D_LIMIT      = 70 << 18;
   localparam int SUM_LIMIT    = 150 << 18;
   localparam int DRIVE_LIMIT  = 15000;
   localparam int FALLBACK_MUL = 20 * 64;     // bang-bang magnitude per gain LSB
   localparam int DRIVE_SCALE  = 100;         // hundredths
   localparam int FRAC_BITS    = 18;

   localparam int GAIN_W    = 16;
   localparam int SPEED_W   = 16;
   localparam int QUALITY_W = 8;
   localparam int DRIVE_W   = 15;
   localparam int INTEG_W   = 24;
   localparam int ERROR_W   = 18;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALLBACK_FWD_GAIN = 3'd0,
      CSR_FALLBACK_BWD_GAIN = 3'd1,
      CSR_PROP_GAIN         = 3'd2,
      CSR_INTEG_GAIN        = 3'd3,
      CSR_DERIV_GAIN        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] fallback_forward_gain;
      logic [GAIN_W-1:0] fallback_backward_gain;
      logic [GAIN_W-1:0] proportional_gain;
      logic [GAIN_W-1:0] integral_gain;
      logic [GAIN_W-1:0] derivative_gain;
   } gains_type;

   typedef struct packed {
      logic                 action;
      logic [SPEED_W-1:0]   target_speed;
      logic [SPEED_W-1:0]   measured_speed;
      logic [QUALITY_W-1:0] flow_quality;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive_out;
      logic               fallback_active;
   } rsp_type;

endpackage

>>> sv/fvpid_csr.sv
// ----------------------------------------------------------------------------
// fvpid_csr
// Gain register file, written through a plain write-enable port.
// ----------------------------------------------------------------------------
module fvpid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [fvpid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fvpid_pkg::GAIN_W-1:0]        csr_write_data,
   output fvpid_pkg::gains_type                gains
);

   fvpid_pkg::gains_type gains_ff;
   fvpid_pkg::gains_type gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         unique case (fvpid_pkg::csr_index_type'(csr_index))
            fvpid_pkg::CSR_FALLBACK_FWD_GAIN: gains_in.fallback_forward_gain  = csr_write_data;
            fvpid_pkg::CSR_FALLBACK_BWD_GAIN: gains_in.fallback_backward_gain = csr_write_data;
            fvpid_pkg::CSR_PROP_GAIN:         gains_in.proportional_gain      = csr_write_data;
            fvpid_pkg::CSR_INTEG_GAIN:        gains_in.integral_gain          = csr_write_data;
            fvpid_pkg::CSR_DERIV_GAIN:        gains_in.derivative_gain        = csr_write_data;
            default:                          gains_in = gains_ff; // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.fallback_forward_gain  <= 16'd4096;
         gains_ff.fallback_backward_gain <= 16'd4096;
         gains_ff.proportional_gain      <= 16'd4096;
         gains_ff.integral_gain          <= 16'd0;
         gains_ff.derivative_gain        <= 16'd0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

>>> sv/fvpid_core.sv
// ----------------------------------------------------------------------------
// fvpid_core
// One control step: target clamp, bang-bang fallback or PID, output scaling,
// and the integrator / error history registers.
// ----------------------------------------------------------------------------
module fvpid_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  fvpid_pkg::req_type   item,
   input  fvpid_pkg::gains_type gains,
   output fvpid_pkg::rsp_type   result
);

   logic signed [fvpid_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [fvpid_pkg::ERROR_W-1:0] prev_err_ff, prev_err_in;
   logic                                 hist_invalid_ff, hist_invalid_in;

   logic signed [fvpid_pkg::SPEED_W-1:0] target_s, measured_s;
   logic signed [11:0]                   target_c;
   logic                                 fallback;
   logic signed [fvpid_pkg::ERROR_W-1:0] err;
   logic signed [34:0]                   p_prod, i_prod;
   logic signed [34:0]                   p_term;
   logic signed [33:0]                   i_inc;
   logic signed [35:0]                   integ_sum;
   logic signed [fvpid_pkg::INTEG_W-1:0] integ_step;
   logic signed [18:0]                   err_diff;
   logic signed [35:0]                   d_prod, d_raw;
   logic signed [25:0]                   d_term;
   logic signed [36:0]                   pid_sum;
   logic signed [27:0]                   fb_mag, fb_sum;
   logic signed [36:0]                   sum_sel;
   logic signed [26:0]                   sum_c;
   logic signed [33:0]                   scaled, scaled_adj;
   logic signed [15:0]                   drive;

   always_comb begin
      target_s   = $signed(item.target_speed);
      measured_s = $signed(item.measured_speed);
      fallback   = item.flow_quality < 8'(fvpid_pkg::QUALITY_MIN);

      if (target_s > 16'(fvpid_pkg::TARGET_LIMIT)) begin
         target_c = 12'(fvpid_pkg::TARGET_LIMIT);
      end else if (target_s < -16'sd1920) begin
         target_c = -12'sd1920;
      end else begin
         target_c = target_s[11:0];
      end

      err = {{6{target_c[11]}}, target_c} - {{2{measured_s[15]}}, measured_s};

      // P and I products share the error
      p_prod = err * $signed({1'b0, gains.proportional_gain});
      i_prod = err * $signed({1'b0, gains.integral_gain});
      p_term = -p_prod;
      i_inc  = 34'(i_prod >>> 1);

      integ_sum = 36'(integ_ff) + 36'(i_inc);
      if (integ_sum > 36'(fvpid_pkg::INT_LIMIT)) begin
         integ_step = 24'(fvpid_pkg::INT_LIMIT);
      end else if (integ_sum < -36'(fvpid_pkg::INT_LIMIT)) begin
         integ_step = -24'(fvpid_pkg::INT_LIMIT);
      end else begin
         integ_step = integ_sum[23:0];
      end

      err_diff = 19'(err) - 19'(prev_err_ff);
      d_prod   = err_diff * $signed({1'b0, gains.derivative_gain});
      d_raw    = -d_prod;
      if (hist_invalid_ff) begin
         d_term = '0;
      end else if (d_raw > 36'(fvpid_pkg::D_LIMIT)) begin
         d_term = 26'(fvpid_pkg::D_LIMIT);
      end else if (d_raw < -36'(fvpid_pkg::D_LIMIT)) begin
         d_term = -26'(fvpid_pkg::D_LIMIT);
      end else begin
         d_term = d_raw[25:0];
      end

      pid_sum = 37'(p_term) - (37'(integ_step) <<< 1) + 37'(d_term);

      // bang-bang: forward gain pulls down, backward gain pushes up
      if (target_c > 12'(fvpid_pkg::DEAD_BAND)) begin
         fb_mag = $signed({1'b0, 27'(gains.fallback_forward_gain)
                                 * 27'(fvpid_pkg::FALLBACK_MUL)});
         fb_sum = -fb_mag;
      end else if (target_c < -12'sd64) begin
         fb_mag = $signed({1'b0, 27'(gains.fallback_backward_gain)
                                 * 27'(fvpid_pkg::FALLBACK_MUL)});
         fb_sum = fb_mag;
      end else begin
         fb_mag = '0;
         fb_sum = '0;
      end

      sum_sel = fallback ? 37'(fb_sum) : pid_sum;
      if (sum_sel > 37'(fvpid_pkg::SUM_LIMIT)) begin
         sum_c = 27'(fvpid_pkg::SUM_LIMIT);
      end else if (sum_sel < -37'(fvpid_pkg::SUM_LIMIT)) begin
         sum_c = -27'(fvpid_pkg::SUM_LIMIT);
      end else begin
         sum_c = sum_sel[26:0];
      end

      // scale to hundredths, truncate toward zero
      scaled     = 34'(sum_c) * 34'(fvpid_pkg::DRIVE_SCALE);
      scaled_adj = scaled[33] ? scaled + 34'((1 << fvpid_pkg::FRAC_BITS) - 1) : scaled;
      drive      = 16'(scaled_adj >>> fvpid_pkg::FRAC_BITS);

      result.drive_out       = drive[fvpid_pkg::DRIVE_W-1:0];
      result.fallback_active = fallback;
   end

   always_comb begin
      integ_in        = integ_ff;
      prev_err_in     = prev_err_ff;
      hist_invalid_in = hist_invalid_ff;
      if (step_en) begin
         if (item.action) begin
            integ_in = '0;
         end else if (fallback) begin
            prev_err_in     = '0;
            hist_invalid_in = 1'b1;
         end else begin
            integ_in        = integ_step;
            prev_err_in     = err;
            hist_invalid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff        <= '0;
         prev_err_ff     <= '0;
         hist_invalid_ff <= 1'b0;
      end else begin
         integ_ff        <= integ_in;
         prev_err_ff     <= prev_err_in;
         hist_invalid_ff <= hist_invalid_in;
      end
   end

endmodule

>>> sv/flow_velocity_pid_with_fallback.sv
// ----------------------------------------------------------------------------
// flow_velocity_pid_with_fallback
// Single-axis optical-flow velocity PID with clamped integrator and a
// bang-bang fallback for low flow quality.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | action, target, measured, quality
//   rsp     | out       | rsp_valid/rsp_ready  | drive_out, fallback_active
//   csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One request per cycle sustained while responses are not stalled; a run
// request gives its response through the request register, one pass
// through the control datapath and the response register. Clear requests
// update the integrator and give no response. Reset clears gains to
// defaults, state to zero and both valid bits. A stalled response holds
// the response register; an empty request register takes one more request.
// ----------------------------------------------------------------------------
module flow_velocity_pid_with_fallback (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [fvpid_pkg::SPEED_W-1:0] req_target_speed,
   input  logic signed [fvpid_pkg::SPEED_W-1:0] req_measured_speed,
   input  logic [fvpid_pkg::QUALITY_W-1:0]     req_flow_quality,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fvpid_pkg::DRIVE_W-1:0] rsp_drive_out,
   output logic                                rsp_fallback_active,
   input  logic                                csr_write_enable,
   input  logic [fvpid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fvpid_pkg::GAIN_W-1:0]        csr_write_data
);

   fvpid_pkg::gains_type gains;
   fvpid_pkg::req_type   item_ff, item_in;
   fvpid_pkg::rsp_type   rsp_ff, rsp_in;
   fvpid_pkg::rsp_type   result;
   logic                 in_vld_ff, in_vld_in;
   logic                 out_vld_ff, out_vld_in;
   logic                 out_free;
   logic                 advance;
   logic                 req_fire;

   fvpid_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .gains            (gains)
   );

   fvpid_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .gains   (gains),
      .result  (result)
   );

   always_comb begin
      out_free  = !out_vld_ff || rsp_ready;
      advance   = in_vld_ff && out_free;
      req_ready = !in_vld_ff || out_free;
      req_fire  = req_valid && req_ready;

      item_in.action         = req_action;
      item_in.target_speed   = req_target_speed;
      item_in.measured_speed = req_measured_speed;
      item_in.flow_quality   = req_flow_quality;

      in_vld_in  = req_fire || (in_vld_ff && !advance);
      out_vld_in = (advance && !item_ff.action) || (out_vld_ff && !rsp_ready);
      rsp_in     = (advance && !item_ff.action) ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_drive_out       = $signed(rsp_ff.drive_out);
   assign rsp_fallback_active = rsp_ff.fallback_active;

endmodule

>>> sv/fvpid_checker.sv
// ----------------------------------------------------------------------------
// fvpid_checker
// Port-level checks for the flow velocity PID controller.
// ----------------------------------------------------------------------------
module fvpid_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_action,
   input logic [fvpid_pkg::QUALITY_W-1:0]     req_flow_quality,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [fvpid_pkg::DRIVE_W-1:0] rsp_drive_out,
   input logic                                rsp_fallback_active
);

   // output stays inside the hundredths range
   drive_range_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_out <= 15'(fvpid_pkg::DRIVE_LIMIT))
                 && (rsp_drive_out >= -15'sd15000))
      else $error("drive_out out of range");

   // a stalled response holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_out)
                                 && $stable(rsp_fallback_active))
      else $error("stalled response changed");

   // a fresh response comes from an earlier accepted run request, with the
   // fallback flag matching that request's quality
   rsp_origin_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && !req_action, 2)
         && (rsp_fallback_active
             == $past(req_flow_quality < 8'(fvpid_pkg::QUALITY_MIN), 2)))
      else $error("response without matching run request");

   reset_clear_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind flow_velocity_pid_with_fallback fvpid_checker u_fvpid_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_action          (req_action),
   .req_flow_quality    (req_flow_quality),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_drive_out       (rsp_drive_out),
   .rsp_fallback_active (rsp_fallback_active)
);
